>>> rtl/core/sps_pkg.sv
`timescale 1ns / 1ps

package sps_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_FINISH = 2'd3
    } sps_state_t;

    // Input op codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic write;       // store the accepted vertex
        logic load_dir;    // capture the query direction
        logic scan_start;  // rewind the scan address
        logic issue;       // read one vertex and advance
        logic load_out;    // move the winner into the output register
    } sps_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic n_zero;      // no vertex takes part
        logic last_issue;  // current address is the last one to read
        logic pipe_idle;   // no vertex in flight
        logic out_free;    // output register can take a result
    } sps_status_t;

endpackage

>>> rtl/core/sps_in_if.sv
`timescale 1ns / 1ps

interface sps_in_if #(
    parameter int COORD_WIDTH = 16,
    parameter int SLOT_W      = 6
);
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic        [SLOT_W-1:0]      slot;
    logic signed [COORD_WIDTH-1:0] vx;
    logic signed [COORD_WIDTH-1:0] vy;
    logic signed [COORD_WIDTH-1:0] vz;

    modport source (output valid, op, slot, vx, vy, vz, input ready);
    modport sink   (input valid, op, slot, vx, vy, vz, output ready);
endinterface

>>> rtl/core/sps_out_if.sv
`timescale 1ns / 1ps

interface sps_out_if #(
    parameter int COORD_WIDTH = 16,
    parameter int SLOT_W      = 6
);
    localparam int DOT_W = 2 * COORD_WIDTH + 1;

    logic                          valid;
    logic                          ready;
    logic        [SLOT_W-1:0]      best_slot;
    logic signed [COORD_WIDTH-1:0] best_x;
    logic signed [COORD_WIDTH-1:0] best_y;
    logic signed [COORD_WIDTH-1:0] best_z;
    logic signed [DOT_W-1:0]       best_dot;
    logic                          empty_res;

    modport source (output valid, best_slot, best_x, best_y, best_z, best_dot, empty_res,
                    input ready);
    modport sink   (input valid, best_slot, best_x, best_y, best_z, best_dot, empty_res,
                    output ready);
endinterface

>>> rtl/core/support_point_search.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Transfer
// in_ch     in   op, slot, vx, vy, vz                             valid && ready
// out_ch    out  best_slot, best_x, best_y, best_z, best_dot,     valid && ready
//                empty_res
// cfg       in   cfg_wdata = point_count                          cfg_we
//
// A vertex write leaves the controller idle, so the next transfer is taken in
// the cycle after. A query runs through its transfer, one memory read a cycle
// for each of the n vertices, a drain of the three pipeline stages (read,
// multiply, sum) until they are seen empty, and the load of the output register.
// An empty set goes from its transfer straight to the load. The single memory
// read port sets the rate of the scan.
// Reset clears point_count and control; vertex storage is undefined until written.
// A held result does not block intake; a finished query waits in place until
// the output register is free.

module support_point_search #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    sps_in_if.sink                                in_ch,
    sps_out_if.source                             out_ch,
    input  logic                                  cfg_we,
    input  logic [$clog2(MAX_POINTS + 1)-1:0]     cfg_wdata
);
    import sps_pkg::*;

    localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    sps_cmd_t    cmd;
    sps_status_t status;
    logic        in_ready;

    // Controller: sequences writes, scan, drain and result load.
    sps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // Datapath: vertex store, dot-product pipeline, best tracker, output register.
    sps_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .SLOT_W      (SLOT_W),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_slot   (in_ch.slot),
        .in_vx     (in_ch.vx),
        .in_vy     (in_ch.vy),
        .in_vz     (in_ch.vz),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_slot  (out_ch.best_slot),
        .out_x     (out_ch.best_x),
        .out_y     (out_ch.best_y),
        .out_z     (out_ch.best_z),
        .out_dot   (out_ch.best_dot),
        .out_empty (out_ch.empty_res)
    );
endmodule

>>> rtl/core/sps_ram.sv
`timescale 1ns / 1ps

module sps_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/core/sps_ctrl.sv
`timescale 1ns / 1ps

module sps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    input  sps_pkg::sps_status_t status,
    output sps_pkg::sps_cmd_t    cmd
);
    import sps_pkg::*;

    sps_state_t state_reg;
    sps_state_t state_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_op == OP_QUERY))
                begin
                    state_next = status.n_zero ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_idle)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.write      = 1'b0;
        cmd.load_dir   = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.issue      = 1'b0;
        cmd.load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.write      = in_valid && (in_op == OP_WRITE);
                cmd.load_dir   = in_valid && (in_op == OP_QUERY);
                cmd.scan_start = in_valid && (in_op == OP_QUERY);
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (state_reg == ST_IDLE) && !cmd.issue)
        else $error("vertex write outside idle");

    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && cmd.load_out |=> (state_reg == ST_IDLE))
        else $error("result load did not return to idle");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && status.last_issue |=> (state_reg == ST_DRAIN))
        else $error("scan did not stop after last vertex");
`endif
endmodule

>>> rtl/core/sps_dp.sv
`timescale 1ns / 1ps

module sps_dp #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16,
    parameter int SLOT_W      = 6,
    parameter int CNT_W       = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CNT_W-1:0]              cfg_wdata,
    input  logic [SLOT_W-1:0]             in_slot,
    input  logic signed [COORD_WIDTH-1:0] in_vx,
    input  logic signed [COORD_WIDTH-1:0] in_vy,
    input  logic signed [COORD_WIDTH-1:0] in_vz,
    input  sps_pkg::sps_cmd_t             cmd,
    output sps_pkg::sps_status_t          status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [SLOT_W-1:0]             out_slot,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic signed [2*COORD_WIDTH:0] out_dot,
    output logic                          out_empty
);
    import sps_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int PW    = 2 * CW;
    localparam int DOT_W = 2 * CW + 1;
    localparam int VW    = 3 * CW;
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_POINTS);
    localparam logic [SLOT_W:0]   MAX_SLOT = (SLOT_W + 1)'(MAX_POINTS);

    // configuration
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_eff;

    // query direction and scan address
    logic signed [CW-1:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [SLOT_W-1:0]    addr_reg;

    // memory
    logic [VW-1:0]  ram_wdata;
    logic [VW-1:0]  ram_rdata;
    logic           ram_we;

    // stage 1: read data
    logic              v1_reg;
    logic [SLOT_W-1:0] idx1_reg;
    logic signed [CW-1:0] rd_x, rd_y, rd_z;

    // stage 2: products
    logic              v2_reg;
    logic [SLOT_W-1:0] idx2_reg;
    logic [VW-1:0]     vert2_reg;
    logic signed [PW-1:0] px_reg, py_reg, pz_reg;

    // stage 3: dot
    logic              v3_reg;
    logic [SLOT_W-1:0] idx3_reg;
    logic [VW-1:0]     vert3_reg;
    logic signed [DOT_W-1:0] dot3_reg;
    logic signed [DOT_W-1:0] dot_next;

    // running best
    logic [SLOT_W-1:0]       best_slot_reg;
    logic [VW-1:0]           best_vert_reg;
    logic signed [DOT_W-1:0] best_dot_reg;
    logic                    take;

    // output register
    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic [VW-1:0]           out_vert_reg;
    logic signed [DOT_W-1:0] out_dot_reg;
    logic                    out_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_wdata;
        end
    end

    assign count_eff = (count_reg > MAX_CNT) ? MAX_CNT : count_reg;

    assign ram_we    = cmd.write && ({1'b0, in_slot} < MAX_SLOT);
    assign ram_wdata = {in_vz, in_vy, in_vx};

    sps_ram #(
        .WIDTH  (VW),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (SLOT_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_slot),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[CW-1:0];
    assign rd_y = ram_rdata[2*CW-1:CW];
    assign rd_z = ram_rdata[3*CW-1:2*CW];

    always_ff @(posedge clk)
    begin
        if (cmd.load_dir)
        begin
            dir_x_reg <= in_vx;
            dir_y_reg <= in_vy;
            dir_z_reg <= in_vz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // hold the pipeline payload; the valid bits qualify it
    always_ff @(posedge clk)
    begin
        idx1_reg  <= addr_reg;
        idx2_reg  <= idx1_reg;
        vert2_reg <= ram_rdata;
        px_reg    <= PW'(rd_x) * PW'(dir_x_reg);
        py_reg    <= PW'(rd_y) * PW'(dir_y_reg);
        pz_reg    <= PW'(rd_z) * PW'(dir_z_reg);
        idx3_reg  <= idx2_reg;
        vert3_reg <= vert2_reg;
        dot3_reg  <= dot_next;
    end

    assign dot_next = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);

    // first vertex always seeds the best; strict compare keeps the lower index on a tie
    assign take = v3_reg && ((idx3_reg == '0) || (dot3_reg > best_dot_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_slot_reg <= idx3_reg;
            best_vert_reg <= vert3_reg;
            best_dot_reg  <= dot3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (count_eff == '0)
            begin
                out_slot_reg  <= '0;
                out_vert_reg  <= '0;
                out_dot_reg   <= '0;
                out_empty_reg <= 1'b1;
            end
            else
            begin
                out_slot_reg  <= best_slot_reg;
                out_vert_reg  <= best_vert_reg;
                out_dot_reg   <= best_dot_reg;
                out_empty_reg <= 1'b0;
            end
        end
    end

    assign status.n_zero     = (count_eff == '0);
    assign status.last_issue = ({1'b0, addr_reg} == (SLOT_W + 1)'(count_eff - 1'b1));
    assign status.pipe_idle  = !(v1_reg || v2_reg || v3_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign out_x     = out_vert_reg[CW-1:0];
    assign out_y     = out_vert_reg[2*CW-1:CW];
    assign out_z     = out_vert_reg[3*CW-1:2*CW];
    assign out_dot   = out_dot_reg;
    assign out_empty = out_empty_reg;

`ifndef SYNTHESIS
    a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(v1_reg || v2_reg || v3_reg))
        else $error("result loaded while vertices in flight");

    a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> $past(cmd.issue))
        else $error("read data valid without a read");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg || out_ready)
        else $error("pending result overwritten");
`endif
endmodule
